FILE: src/rab_pkg.sv
package rab_pkg;

    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    // Store index carried between front and back; wide enough for the largest frame.
    localparam int ADDR_W = 24;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DEST_X  = 3'd0,
        REG_DEST_Y  = 3'd1,
        REG_PIVOT_X = 3'd2,
        REG_PIVOT_Y = 3'd3,
        REG_COEF_00 = 3'd4,
        REG_COEF_01 = 3'd5,
        REG_COEF_10 = 3'd6,
        REG_COEF_11 = 3'd7
    } reg_idx_t;

    localparam logic [7:0]  CHAN_MAX = 8'd255;
    localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

    typedef enum logic {
        MODE_BLIT = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    // Entry of the queue between the address front end and the store back end.
    typedef struct packed {
        logic              is_read;
        logic              in_range;
        logic [31:0]       src_pixel;
        logic [ADDR_W-1:0] address;
    } job_t;

    // (s*a + d*(255-a)) / 255 for 8-bit operands; x/255 as (x + 1 + (x >> 8)) >> 8.
    function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                        input logic [7:0] a);
        logic [16:0] x;
        logic [16:0] q;
        x = ({9'd0, s} * {9'd0, a}) + ({9'd0, d} * {9'd0, CHAN_MAX - a});
        q = (x + 17'd1 + (x >> 8)) >> 8;
        return q[7:0];
    endfunction

endpackage

FILE: src/rotated_alpha_blit.sv
// Frame store blitter: blit words are placed through the origin, pivot and Q2.14 matrix,
// alpha blended with the stored pixel and written back; read words return a stored pixel.
// Every input word gives exactly one result word. After reset the store is swept to white,
// one pixel per cycle; full is high during the sweep. A word passes through the address
// pipe and then through the store sequencer steps (take, read, blend/write, result
// hand-off); the sequencer handles one word at a time and takes no new word until
// the last result is popped. A blit that falls outside the store skips the read and write
// and goes from take straight to result hand-off. A four-word queue between address
// front end and store lets either side stall independently. Configure only while idle.
module rotated_alpha_blit #(
    parameter int FRAME_WIDTH = 256,
    parameter int FRAME_PIXELS = 65536,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        mode,
    input  logic [31:0] src_pixel,
    input  logic [7:0]  offset_x,
    input  logic [7:0]  offset_y,
    input  logic [15:0] read_address,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] pixel_value,
    output logic [15:0] pixel_address,
    output logic        written
);
    import rab_pkg::*;

    logic fr_ready, job_valid, q_full, q_empty, job_pop, clearing;
    job_t job_f, job_b;

    assign full = !fr_ready || clearing;

    rab_front #(
        .FRAME_WIDTH(FRAME_WIDTH),
        .FRAME_PIXELS(FRAME_PIXELS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(push && !full), .in_ready(fr_ready),
        .mode(mode), .src_pixel(src_pixel), .offset_x(offset_x),
        .offset_y(offset_y), .read_address(read_address),
        .job_valid(job_valid), .job_ready(!q_full), .job(job_f)
    );

    rab_queue #(.DEPTH(4)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(job_valid), .full(q_full), .din(job_f),
        .pop(job_pop), .empty(q_empty), .dout(job_b)
    );

    rab_back #(.FRAME_PIXELS(FRAME_PIXELS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_empty(q_empty), .job_pop(job_pop), .job(job_b),
        .clearing(clearing),
        .empty(empty), .pop(pop),
        .pixel_value(pixel_value), .pixel_address(pixel_address),
        .written(written)
    );

endmodule

FILE: src/rab_front.sv
module rab_front #(
    parameter int FRAME_WIDTH = 256,
    parameter int FRAME_PIXELS = 65536,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [15:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [31:0]              src_pixel,
    input  logic [7:0]               offset_x,
    input  logic [7:0]               offset_y,
    input  logic [15:0]              read_address,
    output logic                     job_valid,
    input  logic                     job_ready,
    output rab_pkg::job_t            job
);
    import rab_pkg::*;

    localparam int PW = 64;

    logic signed [9:0]  dest_x_reg, dest_y_reg, pivot_x_reg, pivot_y_reg;
    logic signed [15:0] c00_reg, c01_reg, c10_reg, c11_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            c00_reg <= 16'sd16384;
            c01_reg <= '0;
            c10_reg <= '0;
            c11_reg <= 16'sd16384;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEST_X:  dest_x_reg <= cfg_data[9:0];
                REG_DEST_Y:  dest_y_reg <= cfg_data[9:0];
                REG_PIVOT_X: pivot_x_reg <= cfg_data[9:0];
                REG_PIVOT_Y: pivot_y_reg <= cfg_data[9:0];
                REG_COEF_00: c00_reg <= cfg_data;
                REG_COEF_01: c01_reg <= cfg_data;
                REG_COEF_10: c10_reg <= cfg_data;
                REG_COEF_11: c11_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: products. Stage 2: sums, truncation, linear index.
    logic        s1_valid_reg, s2_valid_reg;
    logic        s1_read_reg;
    logic [31:0] s1_pix_reg;
    logic [15:0] s1_raddr_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [11:0] dx, dy;
    job_t s2_job_reg, s2_job_next;
    logic advance;

    // Whole pipe moves only when stage 2 is empty or the queue takes the oldest job.
    assign advance = !s2_valid_reg || job_ready;
    assign in_ready = advance;
    assign dx = 12'(dest_x_reg) + 12'($unsigned(offset_x)) - 12'(pivot_x_reg);
    assign dy = 12'(dest_y_reg) + 12'($unsigned(offset_y)) - 12'(pivot_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_read_reg <= (mode == MODE_READ);
            s1_pix_reg <= src_pixel;
            s1_raddr_reg <= read_address;
            p00_reg <= 32'(dx) * 32'(c00_reg);
            p01_reg <= 32'(dy) * 32'(c01_reg);
            p10_reg <= 32'(dx) * 32'(c10_reg);
            p11_reg <= 32'(dy) * 32'(c11_reg);
            s2_job_reg <= s2_job_next;
        end
    end

    logic signed [PW-1:0] tx, ty, qx, qy, col, row, idx;
    always_comb
    begin
        tx = PW'(p00_reg) - PW'(p01_reg);
        ty = PW'(p10_reg) + PW'(p11_reg);
        // Truncate toward zero: bias negatives before the arithmetic shift.
        qx = (tx + (tx < 0 ? PW'((64'sd1 <<< COEF_FRAC_BITS) - 1) : PW'(0)))
             >>> COEF_FRAC_BITS;
        qy = (ty + (ty < 0 ? PW'((64'sd1 <<< COEF_FRAC_BITS) - 1) : PW'(0)))
             >>> COEF_FRAC_BITS;
        col = PW'(pivot_x_reg) + qx;
        row = PW'(pivot_y_reg) + qy;
        idx = col + row * PW'(FRAME_WIDTH);
        s2_job_next.is_read = s1_read_reg;
        s2_job_next.src_pixel = s1_pix_reg;
        if (s1_read_reg)
        begin
            s2_job_next.in_range = (PW'(s1_raddr_reg) < PW'(FRAME_PIXELS));
            s2_job_next.address = ADDR_W'(s1_raddr_reg);
        end
        else
        begin
            s2_job_next.in_range = (idx >= 0) && (idx < PW'(FRAME_PIXELS));
            s2_job_next.address = s2_job_next.in_range ? idx[ADDR_W-1:0] : '0;
        end
    end

    assign job_valid = s2_valid_reg;
    assign job = s2_job_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !job_ready |=> s2_valid_reg && $stable(s2_job_reg))
        else $error("front job changed while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> s1_valid_reg == $past(in_valid))
        else $error("front stage 1 lost an item");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_job_reg.is_read && !s2_job_reg.in_range
        |-> s2_job_reg.address == '0)
        else $error("skipped blit carries an address");

endmodule

FILE: src/rab_queue.sv
module rab_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  rab_pkg::job_t din,
    input  logic          pop,
    output logic          empty,
    output rab_pkg::job_t dout
);
    import rab_pkg::*;

    localparam int AW = $clog2(DEPTH);

    job_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> wp_reg == rp_reg)
        else $error("queue pointers differ when empty");
    a_inc: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a word");

endmodule

FILE: src/rab_back.sv
module rab_back #(
    parameter int FRAME_PIXELS = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_empty,
    output logic          job_pop,
    input  rab_pkg::job_t job,
    output logic          clearing,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   pixel_value,
    output logic [15:0]   pixel_address,
    output logic          written
);
    import rab_pkg::*;

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] mem [FRAME_PIXELS];
    logic [31:0] rdata_reg;
    logic [AW:0] clr_reg;
    job_t cur_reg;
    logic [31:0] val_reg;
    logic [15:0] addr_reg;
    logic        wr_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic [31:0] blend;

    always_comb
    begin
        blend[31:24] = cur_reg.src_pixel[7:0];
        blend[23:16] = mix8(cur_reg.src_pixel[15:8], rdata_reg[23:16],
                            cur_reg.src_pixel[7:0]);
        blend[15:8] = mix8(cur_reg.src_pixel[23:16], rdata_reg[15:8],
                           cur_reg.src_pixel[7:0]);
        blend[7:0] = mix8(cur_reg.src_pixel[31:24], rdata_reg[7:0],
                          cur_reg.src_pixel[7:0]);
        mem_we = 1'b0;
        mem_waddr = cur_reg.address[AW-1:0];
        mem_wdata = blend;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
            mem_waddr = clr_reg[AW-1:0];
            mem_wdata = WHITE;
        end
        else if (state_reg == ST_WRITE)
        begin
            // Read words leave the store untouched.
            mem_we = !cur_reg.is_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[cur_reg.address[AW-1:0]];
    end

    assign job_pop = (state_reg == ST_IDLE) && !job_empty;
    assign clearing = (state_reg == ST_CLEAR);
    assign empty = (state_reg != ST_OUT);
    assign pixel_value = val_reg;
    assign pixel_address = addr_reg;
    assign written = wr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            cur_reg <= '0;
            val_reg <= '0;
            addr_reg <= '0;
            wr_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(FRAME_PIXELS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!job_empty)
                    begin
                        cur_reg <= job;
                        if (job.in_range)
                        begin
                            state_reg <= ST_READ;
                        end
                        else
                        begin
                            val_reg <= '0;
                            addr_reg <= job.address[15:0];
                            wr_reg <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_READ:
                begin
                    // Read data for cur_reg arrives in rdata_reg this edge.
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    addr_reg <= cur_reg.address[15:0];
                    if (cur_reg.is_read)
                    begin
                        val_reg <= rdata_reg;
                        wr_reg <= 1'b0;
                    end
                    else
                    begin
                        val_reg <= blend;
                        wr_reg <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && cur_reg.is_read |-> !wr_reg)
        else $error("read item flagged as written");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && !pop |=> state_reg == ST_OUT && $stable(val_reg))
        else $error("result dropped while waiting");
    a_clr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !job_pop)
        else $error("job taken during clear");

endmodule

FILE: tb/rotated_alpha_blit_tb.sv
`timescale 1ns / 1ps

module rotated_alpha_blit_tb;
    import rab_pkg::*;

    localparam int FRAME_W = 256;
    localparam int FRAME_N = 65536;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [15:0] Q_ONE = 16'sd16384;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] address;
        logic        written;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        push;
    logic        full;
    logic        mode;
    logic [31:0] src_pixel;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [15:0] read_address;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] pixel_value;
    logic [15:0] pixel_address;
    logic        written;

    rotated_alpha_blit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .mode(mode), .src_pixel(src_pixel), .offset_x(offset_x), .offset_y(offset_y),
        .read_address(read_address),
        .empty(empty), .pop(pop),
        .pixel_value(pixel_value), .pixel_address(pixel_address), .written(written)
    );

    // Own copy of the block's state.
    logic [31:0]        frame_model [FRAME_N];
    logic signed [9:0]  org_x, org_y, piv_x, piv_y;
    logic signed [15:0] m00, m01, m10, m11;

    pixel_result_t pending_pixels [$];
    logic [15:0]   touched [$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int blits_stored = 0;
    int blits_clipped = 0;
    int burst_left = 0;
    bit random_stalls = 1;
    int hold_request = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] blend_chan(int s, int d, int a);
        return 8'((s * a + d * (255 - a)) / 255);
    endfunction

    // Places and blends one blit, or reads one pixel, updating the store copy.
    function automatic pixel_result_t place_pixel(logic m, logic [31:0] src, logic [7:0] ox,
                                                  logic [7:0] oy, logic [15:0] ra);
        pixel_result_t r;
        longint dx, dy, tx, ty, col, row, idx;
        logic [31:0] d;
        int a;
        r = '0;
        if (m == MODE_READ) begin
            r.value = frame_model[ra];
            r.address = ra;
            return r;
        end
        dx = longint'(org_x) + longint'(ox) - longint'(piv_x);
        dy = longint'(org_y) + longint'(oy) - longint'(piv_y);
        tx = dx * longint'(m00) - dy * longint'(m01);
        ty = dx * longint'(m10) + dy * longint'(m11);
        col = longint'(piv_x) + tx / 16384;
        row = longint'(piv_y) + ty / 16384;
        idx = col + row * FRAME_W;
        if (idx < 0 || idx >= FRAME_N)
            return r;
        d = frame_model[idx];
        a = src[7:0];
        r.value = {src[7:0], blend_chan(src[15:8], d[23:16], a),
                   blend_chan(src[23:16], d[15:8], a), blend_chan(src[31:24], d[7:0], a)};
        r.address = idx[15:0];
        r.written = 1'b1;
        frame_model[idx] = r.value;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
        errors++;
    endtask

    // Result side: check each popped word, then pick the next pop value.
    always @(posedge clk) begin
        pixel_result_t w;
        if (pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected word", pixel_value, 32'h0);
            end
            else begin
                w = pending_pixels.pop_front();
                words_checked++;
                if (pixel_value !== w.value)
                    report_mismatch("pixel_value", pixel_value, w.value);
                if (pixel_address !== w.address)
                    report_mismatch("pixel_address", pixel_address, w.address);
                if (written !== w.written)
                    report_mismatch("written", written, w.written);
            end
        end
        if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= 200;
            pop <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end
        else begin
            pop <= !random_stalls || ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d words outstanding", pending_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(logic m, logic [31:0] src, logic [7:0] ox, logic [7:0] oy,
                             logic [15:0] ra);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        push <= 1'b1;
        mode <= m;
        src_pixel <= src;
        offset_x <= ox;
        offset_y <= oy;
        read_address <= ra;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_pixels.push_back(place_pixel(m, src, ox, oy, ra));
        words_sent++;
        if (m == MODE_BLIT) begin
            if (pending_pixels[$].written) begin
                blits_stored++;
                touched.push_back(pending_pixels[$].address);
            end
            else begin
                blits_clipped++;
            end
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DEST_X:  org_x = v[9:0];
            REG_DEST_Y:  org_y = v[9:0];
            REG_PIVOT_X: piv_x = v[9:0];
            REG_PIVOT_Y: piv_y = v[9:0];
            REG_COEF_00: m00 = v;
            REG_COEF_01: m01 = v;
            REG_COEF_10: m10 = v;
            REG_COEF_11: m11 = v;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_placement(logic [15:0] dxo, logic [15:0] dyo, logic [15:0] pxo,
                                 logic [15:0] pyo, logic [15:0] c00, logic [15:0] c01,
                                 logic [15:0] c10, logic [15:0] c11);
        wait_idle();
        write_reg(REG_DEST_X, dxo);
        write_reg(REG_DEST_Y, dyo);
        write_reg(REG_PIVOT_X, pxo);
        write_reg(REG_PIVOT_Y, pyo);
        write_reg(REG_COEF_00, c00);
        write_reg(REG_COEF_01, c01);
        write_reg(REG_COEF_10, c10);
        write_reg(REG_COEF_11, c11);
    endtask

    task automatic random_read();
        logic [15:0] ra;
        if (touched.size() != 0 && $urandom_range(0, 3) != 0)
            ra = touched[$urandom_range(0, touched.size() - 1)];
        else
            ra = 16'($urandom);
        send_word(MODE_READ, $urandom, 8'($urandom), 8'($urandom), ra);
    endtask

    task automatic random_words(int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                random_read();
            else
                send_word(MODE_BLIT, $urandom, 8'($urandom), 8'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_reset_state();
        // The store comes out of reset white; the default matrix is identity.
        send_word(MODE_READ, 32'h0, 8'h00, 8'h00, 16'h0000);
        send_word(MODE_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_word(MODE_BLIT, 32'h1122_33FF, 8'h00, 8'h00, 16'h0);
        send_word(MODE_BLIT, 32'hFFFF_FF00, 8'hFF, 8'hFF, 16'h0);
        send_word(MODE_BLIT, 32'h0000_0080, 8'h10, 8'h20, 16'h0);
        send_word(MODE_READ, 32'h0, 8'h00, 8'h00, 16'h0000);
        send_word(MODE_READ, 32'h0, 8'h00, 8'h00, 16'hFFFF);
        send_word(MODE_READ, 32'h0, 8'h00, 8'h00, 16'h2010);
    endtask

    task automatic test_edges();
        // Negative origin pushes the point before the store: nothing is written.
        set_placement(16'h0300, 16'h0300, 16'h0000, 16'h0000, Q_ONE, 16'h0, 16'h0, Q_ONE);
        send_word(MODE_BLIT, 32'hAABB_CCDD, 8'h00, 8'h00, 16'h0);
        send_word(MODE_BLIT, 32'hAABB_CCDD, 8'hFF, 8'hFF, 16'h0);
        // A column past the frame width wraps into a later row.
        set_placement(16'h01FF, 16'h0000, 16'h0000, 16'h0000, Q_ONE, 16'h0, 16'h0, Q_ONE);
        send_word(MODE_BLIT, 32'h5566_77C0, 8'h20, 8'h00, 16'h0);
        send_word(MODE_BLIT, 32'h5566_7740, 8'hFF, 8'hFE, 16'h0);
        send_word(MODE_BLIT, 32'h5566_7740, 8'hFF, 8'hFF, 16'h0);
        send_word(MODE_READ, 32'h0, 8'h00, 8'h00, 16'h021F);
        // Rows beyond the last one fall outside the store.
        set_placement(16'h0000, 16'h01FF, 16'h0000, 16'h0000, Q_ONE, 16'h0, 16'h0, Q_ONE);
        send_word(MODE_BLIT, 32'h0102_0304, 8'h05, 8'h00, 16'h0);
        // Extreme matrix entries about a pivot at the far corner.
        set_placement(16'h0200, 16'h01FF, 16'h01FF, 16'h0200, 16'h8000, 16'h7FFF,
                      16'h7FFF, 16'h8000);
        send_word(MODE_BLIT, 32'h8040_20FF, 8'h00, 8'h00, 16'h0);
        send_word(MODE_BLIT, 32'h8040_20FF, 8'hFF, 8'h00, 16'h0);
        send_word(MODE_BLIT, 32'h8040_20FF, 8'h00, 8'hFF, 16'h0);
        send_word(MODE_BLIT, 32'h8040_20FF, 8'hFF, 8'hFF, 16'h0);
    endtask

    task automatic test_rotation(logic [15:0] c, logic [15:0] s, int count);
        set_placement(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)), 16'd128,
                      16'd128, c, s, s, c);
        random_words(count);
    endtask

    task automatic test_backpressure();
        set_placement(16'h0000, 16'h0000, 16'h0000, 16'h0000, Q_ONE, 16'h0, 16'h0, Q_ONE);
        random_stalls = 0;
        hold_request++;
        repeat (30) random_read();
        random_words(30);
        wait_idle();
        random_stalls = 1;
    endtask

    task automatic test_random_placements();
        repeat (6) begin
            set_placement(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                          16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            random_words(20);
        end
    endtask

    initial begin
        for (int i = 0; i < FRAME_N; i++)
            frame_model[i] = WHITE;
        org_x = '0;
        org_y = '0;
        piv_x = '0;
        piv_y = '0;
        m00 = Q_ONE;
        m01 = '0;
        m10 = '0;
        m11 = Q_ONE;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        mode = MODE_BLIT;
        src_pixel = '0;
        offset_x = '0;
        offset_y = '0;
        read_address = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_edges();
        test_rotation(Q_ONE, 16'h0, 120);
        test_rotation(16'd14189, 16'd8192, 80);
        test_rotation(16'h0, 16'hC000, 80);
        test_rotation(16'hC000, 16'h0, 60);
        test_backpressure();
        test_random_placements();
        wait_idle();

        $display("Sent %0d words, checked %0d: %0d blits stored, %0d clipped",
                 words_sent, words_checked, blits_stored, blits_clipped);
        $display("Covered identity, rotated, mirrored, wrapped and extreme placements");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
